[design/mcc_pkg.sv]
// shared types, character codes and letter code tables for the morse codec
package mcc_pkg;

	localparam int NUM_LETTERS = 26;
	localparam int MAX_SYMBOLS = 4;
	localparam int BURST_LEN   = 5;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] LOWER_A  = 8'd97;
	localparam logic [7:0] LOWER_Z  = 8'd122;
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef enum logic [0:0] {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} mode_t;

	typedef struct packed {
		logic [BURST_LEN-1:0][7:0] chars;
		logic [2:0]                count;
	} burst_t;

	typedef struct packed {
		logic [3:0] symbols;
		logic [2:0] length;
		logic       invalid;
		logic       is_slash;
	} token_t;

	function automatic logic [2:0] code_len(input logic [4:0] idx);
		logic [2:0] len;
		unique case (idx)
			5'd4, 5'd19: len = 3'd1;
			5'd0, 5'd8, 5'd12, 5'd13: len = 3'd2;
			5'd3, 5'd6, 5'd10, 5'd14, 5'd17, 5'd18, 5'd20, 5'd22: len = 3'd3;
			5'd1, 5'd2, 5'd5, 5'd7, 5'd9, 5'd11, 5'd15, 5'd16, 5'd21, 5'd23,
			5'd24, 5'd25: len = 3'd4;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [3:0] code_bits(input logic [4:0] idx);
		logic [3:0] bits;
		unique case (idx)
			5'd0:  bits = 4'd2;
			5'd1:  bits = 4'd1;
			5'd2:  bits = 4'd5;
			5'd3:  bits = 4'd1;
			5'd4:  bits = 4'd0;
			5'd5:  bits = 4'd4;
			5'd6:  bits = 4'd3;
			5'd7:  bits = 4'd0;
			5'd8:  bits = 4'd0;
			5'd9:  bits = 4'd14;
			5'd10: bits = 4'd5;
			5'd11: bits = 4'd2;
			5'd12: bits = 4'd3;
			5'd13: bits = 4'd1;
			5'd14: bits = 4'd7;
			5'd15: bits = 4'd6;
			5'd16: bits = 4'd11;
			5'd17: bits = 4'd2;
			5'd18: bits = 4'd0;
			5'd19: bits = 4'd1;
			5'd20: bits = 4'd4;
			5'd21: bits = 4'd8;
			5'd22: bits = 4'd6;
			5'd23: bits = 4'd9;
			5'd24: bits = 4'd13;
			5'd25: bits = 4'd3;
			default: bits = 4'd0;
		endcase
		return bits;
	endfunction

endpackage

[design/morse_code_codec_top.sv]
// top level of the morse codec: input register, encoder, decoder, result buffer
//
// Input channel in_valid/in_ready carries one byte (in_char) and an end of line
// flag per beat. Output channel out_valid/out_ready carries one character per
// beat; last_of_run marks the final beat caused by one input byte. Bytes that
// cause nothing send no beat. cfg_valid/cfg_ready writes direction_mode from
// cfg_data (0 encode, 1 decode); write it only while the block is idle.
// An accepted byte waits in the input register until the result buffer is free,
// then its whole burst is formed in one pass and loaded into the result buffer,
// which offers its first beat. Encoding a letter gives up to five beats, and
// decoding gives at most one beat per byte. The byte rate is thus set by the
// burst length and the result buffer, which sends one beat per cycle while
// out_ready is high.
// The next byte is taken while a burst still drains. When the receiver stalls,
// the buffer holds its beat, then the input register fills and in_ready drops.
// Reset clears the mode to encode, the pending token and all valid flags.
module morse_code_codec_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last_of_run,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	mcc_pkg::mode_t  direction_mode_q;
	logic [7:0]      char_s1;
	logic            eol_s1;
	logic            v_s1;
	logic            free;
	logic            transfer;
	mcc_pkg::burst_t enc_burst;
	mcc_pkg::burst_t dec_burst;
	mcc_pkg::burst_t burst;
	logic            is_decode;

	assign cfg_ready = 1'b1;
	assign is_decode = (direction_mode_q == mcc_pkg::MODE_DECODE);
	assign transfer  = v_s1 && free;
	assign in_ready  = !v_s1 || transfer;
	assign burst     = is_decode ? dec_burst : enc_burst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_mode_q <= mcc_pkg::MODE_ENCODE;
		end else if (cfg_valid && cfg_ready) begin
			direction_mode_q <= mcc_pkg::mode_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (transfer) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
			eol_s1  <= end_of_line;
		end
	end

	mcc_encoder u_encoder (
		.in_char (char_s1),
		.burst   (enc_burst)
	);

	mcc_decoder u_decoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (transfer && is_decode),
		.in_char     (char_s1),
		.end_of_line (eol_s1),
		.burst       (dec_burst)
	);

	mcc_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (transfer && burst.count != 3'd0),
		.burst       (burst),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

`ifndef SYNTHESIS
	// a held byte stays until it moves on
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !in_ready |=> v_s1)
		else $error("input register dropped a byte");

	// a burst is never cut short
	a_run_whole: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("burst ended before its last beat");

	// only symbols and the word mark come before the last beat of a burst
	a_mid_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |->
		out_char == mcc_pkg::CH_DOT || out_char == mcc_pkg::CH_DASH ||
		out_char == mcc_pkg::CH_SLASH)
		else $error("unexpected character inside a burst");
`endif

endmodule

[design/mcc_encoder.sv]
// letter and space to dot/dash character burst
module mcc_encoder (
	input  logic [7:0]      in_char,
	output mcc_pkg::burst_t burst
);

	logic [7:0] lower;
	logic [7:0] diff;
	logic [4:0] idx;
	logic [2:0] len;
	logic [3:0] bits;
	logic       is_letter;

	assign lower     = in_char | mcc_pkg::CASE_BIT;
	assign is_letter = (lower >= mcc_pkg::LOWER_A) && (lower <= mcc_pkg::LOWER_Z);
	assign diff      = lower - mcc_pkg::LOWER_A;
	assign idx       = diff[4:0];
	assign len       = mcc_pkg::code_len(idx);
	assign bits      = mcc_pkg::code_bits(idx);

	always_comb begin
		burst = '0;
		if (in_char == mcc_pkg::CH_SPACE) begin
			burst.chars[0] = mcc_pkg::CH_SLASH;
			burst.chars[1] = mcc_pkg::CH_SPACE;
			burst.count    = 3'd2;
		end else if (is_letter) begin
			for (int i = 0; i < mcc_pkg::BURST_LEN; i++) begin
				if (3'(i) < len) begin
					burst.chars[i] = bits[i % mcc_pkg::MAX_SYMBOLS] ?
						mcc_pkg::CH_DASH : mcc_pkg::CH_DOT;
				end else if (3'(i) == len) begin
					burst.chars[i] = mcc_pkg::CH_SPACE;
				end
			end
			burst.count = len + 3'd1;
		end
	end

endmodule

[design/mcc_decoder.sv]
// token register and dot/dash token to letter lookup
module mcc_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [7:0]      in_char,
	input  logic            end_of_line,
	output mcc_pkg::burst_t burst
);

	mcc_pkg::token_t tok_q;
	mcc_pkg::token_t upd;
	mcc_pkg::token_t src;
	mcc_pkg::token_t nxt;
	logic            is_space;
	logic            closing;
	logic            found;
	logic [7:0]      letter;

	assign is_space = (in_char == mcc_pkg::CH_SPACE);
	assign closing  = is_space || end_of_line;

	// token after taking this byte
	always_comb begin
		upd = tok_q;
		if (in_char == mcc_pkg::CH_DOT || in_char == mcc_pkg::CH_DASH) begin
			if (!tok_q.invalid) begin
				if (tok_q.is_slash || tok_q.length >= 3'(mcc_pkg::MAX_SYMBOLS)) begin
					upd.invalid = 1'b1;
				end else begin
					if (in_char == mcc_pkg::CH_DASH) begin
						upd.symbols = tok_q.symbols | (4'b0001 << tok_q.length[1:0]);
					end
					upd.length = tok_q.length + 3'd1;
				end
			end
		end else if (in_char == mcc_pkg::CH_SLASH) begin
			if (tok_q.length == 3'd0 && !tok_q.is_slash && !tok_q.invalid) begin
				upd.is_slash = 1'b1;
			end else begin
				upd.invalid = 1'b1;
			end
		end else begin
			upd.invalid = 1'b1;
		end
	end

	assign src = is_space ? tok_q : upd;
	assign nxt = closing ? '0 : upd;

	always_comb begin
		found  = 1'b0;
		letter = '0;
		for (int i = 0; i < mcc_pkg::NUM_LETTERS; i++) begin
			if (!found && mcc_pkg::code_len(5'(i)) == src.length &&
				mcc_pkg::code_bits(5'(i)) == src.symbols) begin
				found  = 1'b1;
				letter = mcc_pkg::LOWER_A + 8'(i);
			end
		end
	end

	always_comb begin
		burst = '0;
		if (closing && !src.invalid) begin
			if (src.is_slash) begin
				burst.chars[0] = mcc_pkg::CH_SPACE;
				burst.count    = 3'd1;
			end else if (src.length != 3'd0 && found) begin
				burst.chars[0] = letter;
				burst.count    = 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (advance) begin
			tok_q <= nxt;
		end
	end

endmodule

[design/mcc_serializer.sv]
// result buffer that sends one character beat per cycle while out_ready is high
module mcc_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  mcc_pkg::burst_t burst,
	output logic            free,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_char,
	output logic            last_of_run
);

	logic [mcc_pkg::BURST_LEN-1:0][7:0] buf_q;
	logic [2:0]                         cnt_q;
	logic [2:0]                         idx_q;
	logic                               valid_q;
	logic                               last;

	assign last        = (idx_q == cnt_q - 3'd1);
	assign out_valid   = valid_q;
	assign out_char    = buf_q[idx_q];
	assign last_of_run = last;
	assign free        = !valid_q || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= burst.chars;
			cnt_q <= burst.count;
		end
	end

endmodule
